[hdl/sasb_pkg.sv]
// package for the scaled alpha sprite blitter
// shared constants, codes and the item type carried down the pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sasb_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int SPRITE_TEXELS = 4096;
    localparam int TEX_AW        = $clog2(SPRITE_TEXELS);

    localparam int DIV_STEPS = 7;
    localparam int NUM_W     = 18;
    localparam int ADDR_W    = 14;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_BLEND   = 2'd1;
    localparam logic [1:0] MODE_MIRROR  = 2'd2;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    localparam logic [2:0] CFG_DEST_LEFT     = 3'd0;
    localparam logic [2:0] CFG_DEST_TOP      = 3'd1;
    localparam logic [2:0] CFG_DEST_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_DEST_HEIGHT   = 3'd3;
    localparam logic [2:0] CFG_SPRITE_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_SPRITE_HEIGHT = 3'd5;
    localparam logic [2:0] CFG_ALPHA_GAIN    = 3'd6;

    localparam logic [9:0]  GAIN_RESET   = 10'd256;
    localparam logic [7:0]  MIN_ALPHA    = 8'd10;
    localparam logic [17:0] WEIGHT_CLIP  = 18'd65281;
    localparam logic [16:0] Q16_ONE      = 17'h10000;
    localparam logic [7:0]  OPAQUE_ALPHA = 8'hFF;

    typedef struct packed {
        logic                blend;
        logic                mirror;
        logic                load;
        logic                keep;
        logic signed [12:0]  sx;
        logic signed [12:0]  sy;
        logic [11:0]         tidx;
        logic [31:0]         word;
    } t_item;

endpackage

`default_nettype wire

[hdl/sasb_divider.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on sasb_pkg
`timescale 1ns / 1ps
`default_nettype none

module sasb_divider (
    input  wire logic                      i_clk,
    input  wire logic                      i_ce,
    input  wire logic [sasb_pkg::NUM_W-1:0] i_num,
    input  wire logic [11:0]               i_den,
    output logic [sasb_pkg::DIV_STEPS-1:0] o_quo
);
    import sasb_pkg::*;

    logic [NUM_W-1:0]     r_rem [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo [DIV_STEPS];
    logic [NUM_W-1:0]     n_rem [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_quo [DIV_STEPS];

    always_comb begin
        logic [NUM_W-1:0]     rem_in;
        logic [DIV_STEPS-1:0] quo_in;
        logic [NUM_W:0]       diff;
        for (int s = 0; s < DIV_STEPS; s++) begin
            rem_in = (s == 0) ? i_num : r_rem[(s == 0) ? 0 : s - 1];
            quo_in = (s == 0) ? '0 : r_quo[(s == 0) ? 0 : s - 1];
            diff = {1'b0, rem_in} - (NUM_W'(i_den) << (DIV_STEPS - 1 - s));
            if (!diff[NUM_W]) begin
                n_rem[s] = diff[NUM_W-1:0];
                n_quo[s] = quo_in | (DIV_STEPS'(1) << (DIV_STEPS - 1 - s));
            end else begin
                n_rem[s] = rem_in;
                n_quo[s] = quo_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

`default_nettype wire

[hdl/sasb_fetch.sv]
// texel address calculation and sprite store
// depends on sasb_pkg
`timescale 1ns / 1ps
`default_nettype none

module sasb_fetch (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_ce,
    input  wire logic                i_valid,
    input  wire sasb_pkg::t_item     i_item,
    input  wire logic [6:0]          i_tx,
    input  wire logic [6:0]          i_ty,
    input  wire logic [6:0]          i_sprite_width,
    input  wire logic [6:0]          i_sprite_height,
    output logic                     o_valid,
    output sasb_pkg::t_item          o_item,
    output logic [31:0]              o_texel
);
    import sasb_pkg::*;

    logic [31:0]       r_mem [SPRITE_TEXELS];
    logic              r_valid_a;
    t_item             r_item_a;
    t_item             item_b;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;
    logic              in_range;

    always_comb begin
        logic [6:0] tx;
        logic [6:0] ty;
        ty = (i_ty >= i_sprite_height) ? i_sprite_height - 7'd1 : i_ty;
        tx = (i_tx >= i_sprite_width) ? i_sprite_width - 7'd1 : i_tx;
        if (i_item.mirror) begin
            tx = i_sprite_width - 7'd1 - tx;
        end
        if (i_item.load) begin
            n_addr = ADDR_W'(i_item.tidx);
        end else begin
            n_addr = ADDR_W'(ty) * ADDR_W'(i_sprite_width) + ADDR_W'(tx);
        end
    end

    assign in_range = ({3'b0, r_addr} < 17'(SPRITE_TEXELS));

    always_comb begin
        item_b      = r_item_a;
        item_b.keep = r_item_a.keep & in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            o_valid   <= 1'b0;
        end else if (i_ce) begin
            r_valid_a <= i_valid;
            o_valid   <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_item_a <= i_item;
            r_addr   <= n_addr;
            o_item   <= item_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (r_valid_a && r_item_a.load && in_range) begin
                r_mem[r_addr[TEX_AW-1:0]] <= r_item_a.word;
            end
            o_texel <= r_mem[r_addr[TEX_AW-1:0]];
        end
    end

endmodule

`default_nettype wire

[hdl/sasb_blend.sv]
// alpha weight and channel blend, ends in the output register
// depends on sasb_pkg
`timescale 1ns / 1ps
`default_nettype none

module sasb_blend (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_ce,
    input  wire logic            i_valid,
    input  wire sasb_pkg::t_item i_item,
    input  wire logic [31:0]     i_texel,
    input  wire logic [9:0]      i_alpha_gain,
    output logic                 o_valid,
    output logic signed [12:0]   o_screen_x,
    output logic signed [12:0]   o_screen_y,
    output logic [31:0]          o_new_pixel,
    output logic                 o_write_enable
);
    import sasb_pkg::*;

    logic               r_v1, r_v2, r_v3;
    logic               r_k1, r_k2, r_k3;
    logic signed [12:0] r_sx1, r_sx2, r_sx3, r_sy1, r_sy2, r_sy3;
    logic [23:0]        r_src1, r_src2, r_dst1, r_dst2;
    logic [17:0]        r_p;
    logic [16:0]        r_w, r_inv;
    logic [24:0]        r_pd [3];
    logic [24:0]        r_ps [3];
    logic [16:0]        n_w;
    logic [24:0]        sum [3];

    always_comb begin
        if (r_p >= WEIGHT_CLIP) begin
            n_w = Q16_ONE;
        end else begin
            n_w = 17'(r_p + ((r_p + 18'd1 + (r_p >> 8)) >> 8));
        end
        for (int c = 0; c < 3; c++) begin
            sum[c] = r_pd[c] + r_ps[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_ce) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p    <= 18'(i_texel[31:24]) * 18'(i_alpha_gain);
            r_k1   <= i_item.keep && (i_texel[31:24] >= MIN_ALPHA);
            r_sx1  <= i_item.sx;
            r_sy1  <= i_item.sy;
            r_src1 <= i_texel[23:0];
            r_dst1 <= i_item.word[23:0];

            r_w    <= n_w;
            r_inv  <= Q16_ONE - n_w;
            r_k2   <= r_k1;
            r_sx2  <= r_sx1;
            r_sy2  <= r_sy1;
            r_src2 <= r_src1;
            r_dst2 <= r_dst1;

            for (int c = 0; c < 3; c++) begin
                r_pd[c] <= 25'(r_dst2[c*8 +: 8]) * 25'(r_inv);
                r_ps[c] <= 25'(r_src2[c*8 +: 8]) * 25'(r_w);
            end
            r_k3  <= r_k2;
            r_sx3 <= r_sx2;
            r_sy3 <= r_sy2;

            o_screen_x     <= r_sx3;
            o_screen_y     <= r_sy3;
            o_write_enable <= r_k3;
            o_new_pixel    <= r_k3 ? {OPAQUE_ALPHA, sum[2][23:16], sum[1][23:16],
                                      sum[0][23:16]} : 32'd0;
        end
    end

endmodule

`default_nettype wire

[hdl/scaled_alpha_sprite_blit_top.sv]
// top level of the scaled alpha sprite blitter
// depends on sasb_pkg, sasb_divider, sasb_fetch, sasb_blend
//
// usage
//  input channel (i_valid / o_stall): mode 0 stores texel_value at texel_index,
//  mode 1 blends one pixel of the scaled rectangle, mode 2 the same mirrored,
//  mode 3 is dropped. only blend words produce an output word.
//  output channel (o_valid / i_stall): screen position, new pixel, write enable.
//  configuration (i_cfg_valid / o_cfg_ready): always ready, write only when the
//  pipeline is empty.
//  pipeline stages from accept to o_valid: input register, numerator
//  multiply, 7 divider stages (one quotient bit each), address and store read,
//  4 blend stages. one word enters every cycle while the output is not stalled.
//  when the output is stalled while holding a word the whole pipeline freezes
//  and o_stall rises; nothing is lost or repeated.
//  reset clears pipeline valid bits and config registers (alpha gain to 256); the
//  sprite store is not cleared and must be loaded before it is sampled.
//
`timescale 1ns / 1ps
`default_nettype none

module scaled_alpha_sprite_blit_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_mode,
    input  wire logic [11:0]        i_texel_index,
    input  wire logic [31:0]        i_texel_value,
    input  wire logic [10:0]        i_offset_x,
    input  wire logic [10:0]        i_offset_y,
    input  wire logic [31:0]        i_dest_pixel,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [12:0]      o_screen_x,
    output logic signed [12:0]      o_screen_y,
    output logic [31:0]             o_new_pixel,
    output logic                    o_write_enable,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [11:0]        i_cfg_data
);
    import sasb_pkg::*;

    logic signed [11:0] r_dest_left, r_dest_top;
    logic [11:0]        r_dest_width, r_dest_height;
    logic [6:0]         r_sprite_width, r_sprite_height;
    logic [9:0]         r_alpha_gain;

    logic               ce;
    logic               r_v0, r_v1;
    logic [1:0]         r_mode;
    logic [11:0]        r_tidx;
    logic [31:0]        r_tval, r_dpix;
    logic [10:0]        r_ox, r_oy;
    t_item              n_item, r_item1;
    logic [NUM_W-1:0]   r_nx, r_ny;
    t_item              r_dly [DIV_STEPS];
    logic               r_dv [DIV_STEPS];
    logic [6:0]         qx, qy;
    logic               f_valid;
    t_item              f_item;
    logic [31:0]        f_texel;

    assign ce          = !(o_valid && i_stall);
    assign o_stall     = !ce;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_left     <= '0;
            r_dest_top      <= '0;
            r_dest_width    <= '0;
            r_dest_height   <= '0;
            r_sprite_width  <= '0;
            r_sprite_height <= '0;
            r_alpha_gain    <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEST_LEFT:     r_dest_left     <= i_cfg_data;
                CFG_DEST_TOP:      r_dest_top      <= i_cfg_data;
                CFG_DEST_WIDTH:    r_dest_width    <= i_cfg_data;
                CFG_DEST_HEIGHT:   r_dest_height   <= i_cfg_data;
                CFG_SPRITE_WIDTH:  r_sprite_width  <= i_cfg_data[6:0];
                CFG_SPRITE_HEIGHT: r_sprite_height <= i_cfg_data[6:0];
                CFG_ALPHA_GAIN:    r_alpha_gain    <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic signed [12:0] sx;
        logic signed [12:0] sy;
        sx = 13'(r_dest_left) + $signed({2'b0, r_ox});
        sy = 13'(r_dest_top) + $signed({2'b0, r_oy});
        n_item.blend  = (r_mode == MODE_BLEND) || (r_mode == MODE_MIRROR);
        n_item.mirror = (r_mode == MODE_MIRROR);
        n_item.load   = (r_mode == MODE_LOAD);
        n_item.keep   = (r_dest_width != '0) && (r_dest_height != '0) &&
                        (r_sprite_width != '0) && (r_sprite_height != '0) &&
                        ({1'b0, r_ox} < r_dest_width) && ({1'b0, r_oy} < r_dest_height) &&
                        !sx[12] && (sx < 13'(SCREEN_WIDTH)) &&
                        !sy[12] && (sy < 13'(SCREEN_HEIGHT));
        n_item.sx     = sx;
        n_item.sy     = sy;
        n_item.tidx   = r_tidx;
        n_item.word   = n_item.load ? r_tval : r_dpix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_dv[s] <= 1'b0;
            end
        end else if (ce) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_dv[0] <= r_v1;
            for (int s = 1; s < DIV_STEPS; s++) begin
                r_dv[s] <= r_dv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_mode  <= i_mode;
            r_tidx  <= i_texel_index;
            r_tval  <= i_texel_value;
            r_ox    <= i_offset_x;
            r_oy    <= i_offset_y;
            r_dpix  <= i_dest_pixel;

            r_item1 <= n_item;
            r_nx    <= NUM_W'(r_ox) * NUM_W'(r_sprite_width);
            r_ny    <= NUM_W'(r_oy) * NUM_W'(r_sprite_height);

            r_dly[0] <= r_item1;
            for (int s = 1; s < DIV_STEPS; s++) begin
                r_dly[s] <= r_dly[s-1];
            end
        end
    end

    sasb_divider u_div_x (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (r_nx),
        .i_den (r_dest_width),
        .o_quo (qx)
    );

    sasb_divider u_div_y (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (r_ny),
        .i_den (r_dest_height),
        .o_quo (qy)
    );

    sasb_fetch u_fetch (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ce            (ce),
        .i_valid         (r_dv[DIV_STEPS-1]),
        .i_item          (r_dly[DIV_STEPS-1]),
        .i_tx            (qx),
        .i_ty            (qy),
        .i_sprite_width  (r_sprite_width),
        .i_sprite_height (r_sprite_height),
        .o_valid         (f_valid),
        .o_item          (f_item),
        .o_texel         (f_texel)
    );

    sasb_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ce           (ce),
        .i_valid        (f_valid && f_item.blend),
        .i_item         (f_item),
        .i_texel        (f_texel),
        .i_alpha_gain   (r_alpha_gain),
        .o_valid        (o_valid),
        .o_screen_x     (o_screen_x),
        .o_screen_y     (o_screen_y),
        .o_new_pixel    (o_new_pixel),
        .o_write_enable (o_write_enable)
    );

endmodule

`default_nettype wire
